// ===== hdl/srm_pkg.sv =====
// shared types and codes for the spi register master
package srm_pkg;

    typedef enum logic [1:0] {
        CMD_IDLE       = 2'd0,
        CMD_REG_WRITE  = 2'd1,
        CMD_BURST_READ = 2'd2,
        CMD_BYTE_WRITE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_DATA = 3'd2,
        PH_GAP  = 3'd3,
        PH_READ = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    localparam logic ADDR_READ_BIT  = 1'b1;
    localparam logic ADDR_WRITE_BIT = 1'b0;

    // one tick as seen by the engine, after classification
    typedef struct packed {
        cmd_t       kind;
        logic [7:0] first_byte;
        logic [7:0] write_byte;
        logic [7:0] read_count;
        logic       miso;
    } front_item_t;

    typedef struct packed {
        logic       cs_n;
        logic       sclk;
        logic       mosi;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       busy;
        logic       frame_done;
    } res_t;

endpackage

// ===== hdl/spi_register_master.sv =====
// spi register master top level
// path: input queue, engine, result queue; a result word is on the ports while empty is low
// throughput: one word per cycle unless the result queue is full, set by the single-step frame sequencer
// a two-entry queue on each side lets input and output stall independently
// reset: asynchronous, select high, clock and data low, queues empty, gap register zero
module spi_register_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  cmd,
    input  logic [6:0]  reg_addr,
    input  logic [7:0]  write_byte,
    input  logic [7:0]  read_count,
    input  logic        miso,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        empty,
    input  logic        pop,
    output logic        cs_n,
    output logic        sclk,
    output logic        mosi,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        busy_res,
    output logic        frame_done
);

    import srm_pkg::*;

    localparam int ResW = $bits(res_t);

    logic [15:0]     gap_ticks_reg;
    front_item_t     item;
    logic            item_valid;
    logic            item_pop;
    res_t            res;
    logic            res_push;
    logic            res_full;
    logic [ResW-1:0] res_q_data;
    res_t            res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg <= 16'd0;
        end
        else if (cfg_wr_en)
        begin
            gap_ticks_reg <= cfg_wr_data;
        end
    end

    srm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .reg_addr   (reg_addr),
        .write_byte (write_byte),
        .read_count (read_count),
        .miso       (miso),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    srm_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_gap_ticks (gap_ticks_reg),
        .item           (item),
        .item_valid     (item_valid),
        .item_pop       (item_pop),
        .res_full       (res_full),
        .res            (res),
        .res_push       (res_push)
    );

    srm_fifo #(
        .WIDTH (ResW)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_q_data),
        .empty   (empty)
    );

    assign res_out    = res_t'(res_q_data);
    assign cs_n       = res_out.cs_n;
    assign sclk       = res_out.sclk;
    assign mosi       = res_out.mosi;
    assign read_byte  = res_out.read_byte;
    assign read_valid = res_out.read_valid;
    assign busy_res   = res_out.busy;
    assign frame_done = res_out.frame_done;

    // select goes high only as the frame closes
    a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.frame_done |-> res.cs_n && !res.busy)
        else $error("frame end word without select high and idle");

    // a read byte completes on a clock-high tick inside a frame
    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        res_push && res.read_valid |-> !res.cs_n && res.sclk && res.busy)
        else $error("read byte outside a frame clock-high tick");

    // an accepted word is visible to the engine on the next cycle
    a_front_fill: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full |=> item_valid)
        else $error("accepted word missing from front queue");

    // the engine never produces a word into a full result queue
    a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result word pushed into full queue");

endmodule

// ===== hdl/srm_fifo.sv =====
// two-entry first-in first-out queue
module srm_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/srm_front.sv =====
// front end: takes input words, classifies the command, queues them for the engine
module srm_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [6:0]          reg_addr,
    input  logic [7:0]          write_byte,
    input  logic [7:0]          read_count,
    input  logic                miso,
    output srm_pkg::front_item_t item,
    output logic                item_valid,
    input  logic                item_pop
);

    import srm_pkg::*;

    localparam int ItemW = $bits(front_item_t);

    front_item_t      cls;
    logic [ItemW-1:0] q_data;
    logic             q_empty;

    // first byte on the wire: address with direction bit, or the lone data byte
    always_comb
    begin
        cls.kind       = cmd_t'(cmd);
        cls.write_byte = write_byte;
        cls.read_count = read_count;
        cls.miso       = miso;
        unique case (cmd_t'(cmd))
            CMD_BYTE_WRITE: cls.first_byte = write_byte;
            CMD_BURST_READ: cls.first_byte = {ADDR_READ_BIT, reg_addr};
            default:        cls.first_byte = {ADDR_WRITE_BIT, reg_addr};
        endcase
    end

    srm_fifo #(
        .WIDTH (ItemW)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (cls),
        .full    (full),
        .pop     (item_pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    assign item       = front_item_t'(q_data);
    assign item_valid = !q_empty;

endmodule

// ===== hdl/srm_engine.sv =====
// back end: serial frame sequencer, one pin tick per word
module srm_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          byte_gap_ticks,
    input  srm_pkg::front_item_t item,
    input  logic                 item_valid,
    output logic                 item_pop,
    input  logic                 res_full,
    output srm_pkg::res_t        res,
    output logic                 res_push
);

    import srm_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    cmd_t        kind_reg;
    cmd_t        kind_next;
    logic [7:0]  out_shift_reg;
    logic [7:0]  out_shift_next;
    logic [7:0]  in_shift_reg;
    logic [7:0]  in_shift_next;
    logic [3:0]  bit_count_reg;
    logic [3:0]  bit_count_next;
    logic [7:0]  bytes_left_reg;
    logic [7:0]  bytes_left_next;
    logic [15:0] gap_count_reg;
    logic [15:0] gap_count_next;
    logic [7:0]  pending_reg;
    logic [7:0]  pending_next;
    logic        cs_n_reg;
    logic        cs_n_next;
    logic        sclk_reg;
    logic        sclk_next;
    logic        mosi_reg;
    logic        mosi_next;

    logic        step;
    logic [3:0]  bit_inc;
    logic        byte_end;
    logic [7:0]  bl_dec;
    logic [15:0] gap_dec;
    logic        gap_on;
    logic [7:0]  in_shift_sh;

    assign step        = item_valid && !res_full;
    assign item_pop    = step;
    assign res_push    = step;
    assign bit_inc     = bit_count_reg + 4'd1;
    assign byte_end    = (bit_inc == 4'd0);
    assign bl_dec      = bytes_left_reg - 8'd1;
    assign gap_dec     = gap_count_reg - 16'd1;
    assign gap_on      = (byte_gap_ticks != 16'd0);
    assign in_shift_sh = {in_shift_reg[6:0], item.miso};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (item.kind != CMD_IDLE)
                    begin
                        phase_next = (item.kind == CMD_BYTE_WRITE) ? PH_DATA : PH_ADDR;
                    end
                end
                PH_ADDR:
                begin
                    if (byte_end)
                    begin
                        if (kind_reg == CMD_REG_WRITE)
                        begin
                            phase_next = PH_DATA;
                        end
                        else if (kind_reg == CMD_BURST_READ)
                        begin
                            if (bytes_left_reg == 8'd0)
                            begin
                                phase_next = PH_END;
                            end
                            else
                            begin
                                phase_next = gap_on ? PH_GAP : PH_READ;
                            end
                        end
                        else
                        begin
                            phase_next = PH_END;
                        end
                    end
                end
                PH_DATA:
                begin
                    if (byte_end)
                    begin
                        phase_next = PH_END;
                    end
                end
                PH_READ:
                begin
                    if (byte_end)
                    begin
                        if (bl_dec == 8'd0)
                        begin
                            phase_next = PH_END;
                        end
                        else
                        begin
                            phase_next = gap_on ? PH_GAP : PH_READ;
                        end
                    end
                end
                PH_GAP:
                begin
                    if (gap_dec == 16'd0)
                    begin
                        phase_next = PH_READ;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result word
    always_comb
    begin
        kind_next       = kind_reg;
        out_shift_next  = out_shift_reg;
        in_shift_next   = in_shift_reg;
        bit_count_next  = bit_count_reg;
        bytes_left_next = bytes_left_reg;
        gap_count_next  = gap_count_reg;
        pending_next    = pending_reg;
        cs_n_next       = cs_n_reg;
        sclk_next       = sclk_reg;
        mosi_next       = mosi_reg;
        res.read_byte   = 8'd0;
        res.read_valid  = 1'b0;
        res.frame_done  = 1'b0;
        if (step)
        begin
            unique case (phase_reg) inside
                PH_IDLE:
                begin
                    if (item.kind != CMD_IDLE)
                    begin
                        cs_n_next       = 1'b0;
                        kind_next       = item.kind;
                        bit_count_next  = 4'd0;
                        pending_next    = item.write_byte;
                        bytes_left_next = item.read_count;
                        out_shift_next  = item.first_byte;
                    end
                end
                PH_ADDR, PH_DATA, PH_READ:
                begin
                    if (!bit_count_reg[0])
                    begin
                        sclk_next = 1'b0;
                        if (phase_reg != PH_READ)
                        begin
                            mosi_next = out_shift_reg[7];
                        end
                    end
                    else
                    begin
                        sclk_next = 1'b1;
                        if (phase_reg == PH_READ)
                        begin
                            in_shift_next = in_shift_sh;
                        end
                        else
                        begin
                            out_shift_next = {out_shift_reg[6:0], 1'b0};
                        end
                    end
                    bit_count_next = bit_inc;
                    if (byte_end)
                    begin
                        if (phase_reg == PH_ADDR && kind_reg == CMD_REG_WRITE)
                        begin
                            out_shift_next = pending_reg;
                        end
                        if (phase_reg == PH_READ)
                        begin
                            res.read_valid  = 1'b1;
                            res.read_byte   = in_shift_sh;
                            bytes_left_next = bl_dec;
                        end
                    end
                end
                PH_GAP:
                begin
                    gap_count_next = gap_dec;
                end
                PH_END:
                begin
                    cs_n_next      = 1'b1;
                    kind_next      = CMD_IDLE;
                    res.frame_done = 1'b1;
                end
                default: kind_next = CMD_IDLE;
            endcase
            // a new read byte starts from a clean shifter
            if (phase_next == PH_READ && (phase_reg != PH_READ || byte_end))
            begin
                in_shift_next  = 8'd0;
                bit_count_next = 4'd0;
            end
            // gap length is latched when the gap starts
            if (phase_next == PH_GAP && phase_reg != PH_GAP)
            begin
                gap_count_next = byte_gap_ticks;
            end
        end
        res.cs_n = cs_n_next;
        res.sclk = sclk_next;
        res.mosi = mosi_next;
        res.busy = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= CMD_IDLE;
            out_shift_reg  <= 8'd0;
            in_shift_reg   <= 8'd0;
            bit_count_reg  <= 4'd0;
            bytes_left_reg <= 8'd0;
            gap_count_reg  <= 16'd0;
            pending_reg    <= 8'd0;
            cs_n_reg       <= 1'b1;
            sclk_reg       <= 1'b0;
            mosi_reg       <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            out_shift_reg  <= out_shift_next;
            in_shift_reg   <= in_shift_next;
            bit_count_reg  <= bit_count_next;
            bytes_left_reg <= bytes_left_next;
            gap_count_reg  <= gap_count_next;
            pending_reg    <= pending_next;
            cs_n_reg       <= cs_n_next;
            sclk_reg       <= sclk_next;
            mosi_reg       <= mosi_next;
        end
    end

endmodule

// ===== tb/spi_register_master_tb.sv =====
// testbench for the spi register master: tick-level frame prediction with random queue handshakes
module spi_register_master_tb;

    import srm_pkg::*;

    class spi_frame_scoreboard;
        logic [15:0] gap_reg;
        cmd_t        kind;
        phase_t      phase;
        logic [7:0]  tx_shift;
        logic [7:0]  rx_shift;
        logic [3:0]  half_bits;
        logic [7:0]  bytes_left;
        logic [15:0] gap_left;
        logic [7:0]  data_byte;
        logic        cs_lvl;
        logic        clk_lvl;
        logic        dat_lvl;
        res_t        expected_words[$];
        int          errors;

        function new();
            gap_reg    = '0;
            kind       = CMD_IDLE;
            phase      = PH_IDLE;
            tx_shift   = '0;
            rx_shift   = '0;
            half_bits  = '0;
            bytes_left = '0;
            gap_left   = '0;
            data_byte  = '0;
            cs_lvl     = 1'b1;
            clk_lvl    = 1'b0;
            dat_lvl    = 1'b0;
            errors     = 0;
        endfunction

        function void set_gap(logic [15:0] ticks);
            gap_reg = ticks;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // next byte of a burst read, after the programmed wait if there is one, or the frame end when none is left
        function void next_read_byte();
            if (bytes_left == 8'd0)
                phase = PH_END;
            else if (gap_reg != 16'd0)
            begin
                gap_left = gap_reg;
                phase    = PH_GAP;
            end
            else
            begin
                rx_shift  = '0;
                half_bits = '0;
                phase     = PH_READ;
            end
        endfunction

        // one accepted tick: advance the frame and queue the word it should give
        function void take_tick(cmd_t op, logic [6:0] addr, logic [7:0] data,
                                logic [7:0] count, logic sdi);
            res_t w;
            w = '0;
            case (phase)
                PH_IDLE:
                begin
                    if (op != CMD_IDLE)
                    begin
                        cs_lvl     = 1'b0;
                        kind       = op;
                        half_bits  = '0;
                        data_byte  = data;
                        bytes_left = count;
                        if (op == CMD_BYTE_WRITE)
                        begin
                            tx_shift = data;
                            phase    = PH_DATA;
                        end
                        else
                        begin
                            tx_shift = (op == CMD_BURST_READ) ? {ADDR_READ_BIT, addr}
                                                              : {ADDR_WRITE_BIT, addr};
                            phase    = PH_ADDR;
                        end
                    end
                end
                PH_ADDR, PH_DATA, PH_READ:
                begin
                    if (!half_bits[0])
                    begin
                        clk_lvl = 1'b0;
                        if (phase != PH_READ)
                            dat_lvl = tx_shift[7];
                    end
                    else
                    begin
                        clk_lvl = 1'b1;
                        if (phase == PH_READ)
                            rx_shift = {rx_shift[6:0], sdi};
                        else
                            tx_shift = {tx_shift[6:0], 1'b0};
                    end
                    half_bits = half_bits + 4'd1;
                    if (half_bits == 4'd0)
                    begin
                        if (phase == PH_ADDR)
                        begin
                            if (kind == CMD_REG_WRITE)
                            begin
                                tx_shift = data_byte;
                                phase    = PH_DATA;
                            end
                            else if (kind == CMD_BURST_READ)
                                next_read_byte();
                            else
                                phase = PH_END;
                        end
                        else if (phase == PH_DATA)
                            phase = PH_END;
                        else
                        begin
                            w.read_valid = 1'b1;
                            w.read_byte  = rx_shift;
                            bytes_left   = bytes_left - 8'd1;
                            next_read_byte();
                        end
                    end
                end
                PH_GAP:
                begin
                    gap_left = gap_left - 16'd1;
                    if (gap_left == 16'd0)
                    begin
                        rx_shift  = '0;
                        half_bits = '0;
                        phase     = PH_READ;
                    end
                end
                PH_END:
                begin
                    cs_lvl       = 1'b1;
                    w.frame_done = 1'b1;
                    phase        = PH_IDLE;
                    kind         = CMD_IDLE;
                end
                default:
                begin
                    phase = PH_IDLE;
                    kind  = CMD_IDLE;
                end
            endcase
            w.cs_n = cs_lvl;
            w.sclk = clk_lvl;
            w.mosi = dat_lvl;
            w.busy = (phase != PH_IDLE);
            expected_words.push_back(w);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_word(res_t got);
            res_t want;
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: result word with none expected, expected nothing, got %h",
                             $time, got);
                return;
            end
            want = expected_words.pop_front();
            compare_field("cs_n", want.cs_n, got.cs_n);
            compare_field("sclk", want.sclk, got.sclk);
            compare_field("mosi", want.mosi, got.mosi);
            compare_field("read_byte", want.read_byte, got.read_byte);
            compare_field("read_valid", want.read_valid, got.read_valid);
            compare_field("busy_res", want.busy, got.busy);
            compare_field("frame_done", want.frame_done, got.frame_done);
        endfunction

        function void report_leftover();
            if (expected_words.size() != 0)
            begin
                errors++;
                $display("%0t: words missing, expected %0d more, got 0", $time,
                         expected_words.size());
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  cmd;
    logic [6:0]  reg_addr;
    logic [7:0]  write_byte;
    logic [7:0]  read_count;
    logic        miso;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        empty;
    logic        pop;
    logic        cs_n;
    logic        sclk;
    logic        mosi;
    logic [7:0]  read_byte;
    logic        read_valid;
    logic        busy_res;
    logic        frame_done;

    spi_frame_scoreboard frames;
    int                  ticks_sent;
    bit                  steady;

    spi_register_master i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .cmd         (cmd),
        .reg_addr    (reg_addr),
        .write_byte  (write_byte),
        .read_count  (read_count),
        .miso        (miso),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .empty       (empty),
        .pop         (pop),
        .cs_n        (cs_n),
        .sclk        (sclk),
        .mosi        (mosi),
        .read_byte   (read_byte),
        .read_valid  (read_valid),
        .busy_res    (busy_res),
        .frame_done  (frame_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // no gaps during long frames and in calm stretches
    function automatic int sender_gap();
        int r;
        if (steady || (ticks_sent / 150) % 4 == 1)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    task automatic send_tick(cmd_t op, logic [6:0] addr, logic [7:0] data, logic [7:0] count,
                             logic sdi);
        int gap;
        cmd        <= op;
        reg_addr   <= addr;
        write_byte <= data;
        read_count <= count;
        miso       <= sdi;
        push       <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        frames.take_tick(op, addr, data, count, sdi);
        ticks_sent++;
        gap = sender_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // tick inside a frame: mostly idle, sometimes a command that must be ignored
    task automatic frame_tick();
        cmd_t op;
        int   r;
        r  = $urandom_range(0, 99);
        op = CMD_IDLE;
        if ((frames.phase == PH_END) ? (r < 50) : (r < 20))
            op = cmd_t'($urandom_range(1, 3));
        send_tick(op, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic idle_ticks(int n);
        repeat (n) send_tick(CMD_IDLE, 7'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    task automatic run_frame(cmd_t op, logic [6:0] addr, logic [7:0] data, logic [7:0] count);
        while (frames.phase != PH_IDLE)
            frame_tick();
        send_tick(op, addr, data, count, 1'($urandom));
        while (frames.phase != PH_IDLE)
            frame_tick();
    endtask

    // wait until every word sent has come back
    task automatic settle();
        push <= 1'b0;
        while (frames.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_gap(logic [15:0] ticks);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        frames.set_gap(ticks);
    endtask

    // result side: random stalls plus one long hold-off so the input queue backs up
    initial
    begin
        int   cycle;
        int   hold;
        bit   want_pop;
        res_t got;
        cycle = 0;
        hold  = 0;
        pop   = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle++;
            if (pop && !empty)
            begin
                got.cs_n       = cs_n;
                got.sclk       = sclk;
                got.mosi       = mosi;
                got.read_byte  = read_byte;
                got.read_valid = read_valid;
                got.busy       = busy_res;
                got.frame_done = frame_done;
                frames.check_word(got);
            end
            if (cycle == 300)
                hold = 200;
            if (hold > 0)
            begin
                hold--;
                want_pop = 1'b0;
            end
            else if (!steady && (cycle / 512) % 4 != 0 && $urandom_range(0, 99) < 15)
            begin
                want_pop = 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 2);
            end
            else
                want_pop = 1'b1;
            pop <= want_pop;
        end
    end

    initial
    begin
        int         start;
        int         nframes;
        int         pick;
        logic [7:0] count;
        rst_n       = 1'b0;
        push        = 1'b0;
        cmd         = CMD_IDLE;
        reg_addr    = '0;
        write_byte  = '0;
        read_count  = '0;
        miso        = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        steady      = 1'b0;
        ticks_sent  = 0;
        frames      = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_gap(16'd0);
        run_frame(CMD_REG_WRITE, 7'h7f, 8'hff, 8'hff);
        run_frame(CMD_REG_WRITE, 7'h00, 8'h00, 8'h00);
        run_frame(CMD_BYTE_WRITE, 7'h55, 8'ha5, 8'h80);
        run_frame(CMD_BURST_READ, 7'h7f, 8'hff, 8'd0);
        run_frame(CMD_BURST_READ, 7'h2a, 8'h00, 8'd1);
        run_frame(CMD_BURST_READ, 7'h00, 8'h3c, 8'd2);
        idle_ticks(3);
        write_gap(16'd1);
        run_frame(CMD_BURST_READ, 7'h40, 8'h00, 8'd3);

        // gap length changed while a wait is running: the running one keeps its length
        write_gap(16'd5);
        send_tick(CMD_BURST_READ, 7'h11, 8'h00, 8'd2, 1'b0);
        while (frames.phase != PH_GAP)
            frame_tick();
        frame_tick();
        frame_tick();
        write_gap(16'd2);
        while (frames.phase != PH_IDLE)
            frame_tick();

        // a wait longer than one byte of the counter
        steady = 1'b1;
        write_gap(16'h0101);
        run_frame(CMD_BURST_READ, 7'h12, 8'h00, 8'd1);
        run_frame(CMD_BURST_READ, 7'h13, 8'h00, 8'd0);
        steady = 1'b0;

        start   = ticks_sent;
        nframes = 0;
        while (ticks_sent - start < 150)
        begin
            if (nframes % 6 == 0)
            begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    write_gap(16'd0);
                else if (pick == 1)
                    write_gap(16'd1);
                else
                    write_gap(16'($urandom_range(2, 5)));
            end
            if ($urandom_range(0, 2) == 0)
                idle_ticks($urandom_range(1, 3));
            count = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(4, 12))
                                                : 8'($urandom_range(0, 2));
            run_frame(cmd_t'($urandom_range(1, 3)), 7'($urandom), 8'($urandom), count);
            nframes++;
        end

        settle();
        repeat (10) @(posedge clk);
        frames.report_leftover();
        if (frames.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
